@@ sv/lowest_free_descriptor_table_macros.svh @@
// assertion macros used by the descriptor table rtl
// no dependencies; included inside the module body
`ifndef LOWEST_FREE_DESCRIPTOR_TABLE_MACROS_SVH
`define LOWEST_FREE_DESCRIPTOR_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LFDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define LFDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/lfdt_pkg.sv @@
// shared types and codes for the lowest-free descriptor table
// no dependencies
package lfdt_pkg;

    localparam int DESC_W   = 8;
    localparam int HANDLE_W = 32;
    localparam int DOUT_W   = 7;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_FREE  = 2'd1;
    localparam t_status ST_BAD_DESC = 2'd2;

    typedef logic t_req;
    localparam t_req REQ_ALLOC   = 1'b0;
    localparam t_req REQ_RELEASE = 1'b1;

    // result of the lowest-free search
    typedef struct packed {
        logic              found;
        logic [DESC_W-1:0] idx;
    } t_find;

endpackage

@@ sv/lowest_free_descriptor_table.sv @@
// Lowest-free descriptor table. An allocate word (tuser 0) grants the
// lowest free descriptor in LOWEST_DESC..HIGHEST_DESC, binds the handle
// from tdata to it and returns it; with none free it returns a no-free
// status. A release word (tuser 1) frees an in-use descriptor and returns
// its bound handle, or returns a bad-descriptor status. One word is taken
// every clock cycle while the output is not stalled: the in-use map lives
// in flip-flops cleared by reset and a priority encoder over it picks the
// grant in the accept cycle, and the handle memory is written or read once
// in that same cycle. A result passes the accept stage with the registered
// memory read, then the output register. A stalled output holds the input
// once the accept stage is full. No clearing pass follows reset; the block
// is ready at once.
// depends on lfdt_pkg, lfdt_find, lfdt_hstore and the assertion macro header
module lowest_free_descriptor_table #(
    parameter int LOWEST_DESC  = 3,
    parameter int HIGHEST_DESC = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // handle_in[31:0], desc_in[39:32]
    input  logic        s_axis_tuser,   // req_type[0]
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // desc_out[6:0], handle_out[38:7], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import lfdt_pkg::*;
    `include "lowest_free_descriptor_table_macros.svh"

    localparam int DEPTH = HIGHEST_DESC + 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // request fields
    logic                s_acc;
    t_req                req_type;
    logic [HANDLE_W-1:0] handle_in;
    logic [DESC_W-1:0]   desc_in;
    logic [IDX_W-1:0]    rel_idx;
    logic                rel_ok;
    logic                alloc_hit;
    logic                rel_hit;

    // in-use map and lowest-free search
    logic [DEPTH-1:0]    r_in_use, n_in_use;
    t_find               find;
    logic [IDX_W-1:0]    grant_idx;
    logic [IDX_W+DOUT_W-1:0] grant_ext;

    // accept stage
    logic                r_s1_vld;
    t_status             r_s1_status;
    logic [DOUT_W-1:0]   r_s1_desc;
    logic                r_s1_rel;
    logic [HANDLE_W-1:0] rd_data;
    logic                s1_adv;

    // output register
    logic                r_out_vld;
    t_status             r_out_status;
    logic [DOUT_W-1:0]   r_out_desc;
    logic [HANDLE_W-1:0] r_out_handle;
    logic                out_fail;

    assign req_type  = s_axis_tuser;
    assign handle_in = s_axis_tdata[HANDLE_W-1:0];
    assign desc_in   = s_axis_tdata[HANDLE_W +: DESC_W];
    assign rel_idx   = desc_in[IDX_W-1:0];

    // stage 1 moves on when the output register is empty or being drained
    assign s1_adv        = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    lfdt_find #(
        .DEPTH (DEPTH),
        .LOW   (LOWEST_DESC)
    ) u_find (
        .i_in_use (r_in_use),
        .o_find   (find)
    );

    assign grant_idx = find.idx[IDX_W-1:0];
    // granted descriptor zero-extended; its low DOUT_W bits go to desc_out
    assign grant_ext = {{DOUT_W{1'b0}}, grant_idx};

    // release is legal only for an in-range descriptor that is in use
    assign rel_ok = (desc_in >= DESC_W'(LOWEST_DESC))
                 && (desc_in <= DESC_W'(HIGHEST_DESC))
                 && r_in_use[rel_idx];

    // accepted grant and accepted good release
    assign alloc_hit = s_acc && (req_type == REQ_ALLOC) && find.found;
    assign rel_hit   = s_acc && (req_type == REQ_RELEASE) && rel_ok;

    always_comb begin
        n_in_use = r_in_use;
        if (s_acc) begin
            if (req_type == REQ_ALLOC) begin
                if (find.found) begin
                    n_in_use[grant_idx] = 1'b1;
                end
            end else if (rel_ok) begin
                n_in_use[rel_idx] = 1'b0;
            end
        end
    end

    lfdt_hstore #(
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_hstore (
        .i_clk     (i_clk),
        .i_wr_en   (alloc_hit),
        .i_wr_addr (grant_idx),
        .i_wr_data (handle_in),
        .i_rd_en   (rel_hit),
        .i_rd_addr (rel_idx),
        .o_rd_data (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use  <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_use <= n_in_use;
            if (s_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // accept stage payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            if (req_type == REQ_ALLOC) begin
                r_s1_rel    <= 1'b0;
                r_s1_status <= find.found ? ST_OK : ST_NO_FREE;
                r_s1_desc   <= find.found ? grant_ext[DOUT_W-1:0] : '0;
            end else begin
                r_s1_rel    <= rel_ok;
                r_s1_status <= rel_ok ? ST_OK : ST_BAD_DESC;
                r_s1_desc   <= '0;
            end
        end
    end

    // output register payload; handle comes from the memory read
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_status <= r_s1_status;
            r_out_desc   <= r_s1_desc;
            r_out_handle <= r_s1_rel ? rd_data : '0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_handle, r_out_desc};

    assign out_fail = r_out_vld && (r_out_status != ST_OK);

    // a grant marks its descriptor used
    `LFDT_ASSERT_NEXT(a_grant_sets, i_clk, i_rst_n, alloc_hit, r_in_use[$past(grant_idx)])
    // a good release clears its descriptor
    `LFDT_ASSERT_NEXT(a_release_clears, i_clk, i_rst_n, rel_hit, !r_in_use[$past(rel_idx)])
    // the search only reports a descriptor that is free
    `LFDT_ASSERT_IMPL(a_find_free, i_clk, i_rst_n, find.found, !r_in_use[grant_idx])
    // failed results carry no descriptor and no handle
    `LFDT_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, out_fail, !(|{r_out_desc, r_out_handle}))

endmodule

@@ sv/lfdt_find.sv @@
// priority encoder: lowest clear bit of the in-use map at or above the floor
// depends on lfdt_pkg
module lfdt_find #(
    parameter int DEPTH = 128,
    parameter int LOW   = 3
) (
    input  logic [DEPTH-1:0]    i_in_use,
    output lfdt_pkg::t_find     o_find
);
    import lfdt_pkg::*;

    always_comb begin
        o_find = '0;
        // scan downward so the lowest free entry is the last one taken
        for (int i = DEPTH - 1; i >= LOW; i--) begin
            if (!i_in_use[i]) begin
                o_find.found = 1'b1;
                o_find.idx   = DESC_W'(i);
            end
        end
    end

endmodule

@@ sv/lfdt_hstore.sv @@
// handle memory: one write port, one read port with registered read data
// depends on lfdt_pkg
module lfdt_hstore #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [lfdt_pkg::HANDLE_W-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [lfdt_pkg::HANDLE_W-1:0] o_rd_data
);
    import lfdt_pkg::*;

    logic [HANDLE_W-1:0] r_mem [DEPTH];
    logic [HANDLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
